// ----- rtl/adc_scan_average_sequencer_defines.svh -----
`ifndef ADC_SCAN_AVERAGE_SEQUENCER_DEFINES_SVH
`define ADC_SCAN_AVERAGE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define ASAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define ASAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/adc_sas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package adc_sas_pkg;

  localparam int CHANNELS_DEF    = 18;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths.
  localparam int CH_W     = 5;
  localparam int CH_SLOTS = 32;
  localparam int SMP_W    = 12;
  localparam int RES_W    = 12;
  localparam int CNT_W    = 8;
  localparam int MASK_W   = 18;
  localparam int CFG_W    = 18;
  localparam int ACC_W    = SMP_W + CNT_W;
  localparam int DIV_CNT_W = $clog2(ACC_W);

  localparam logic [CH_W-1:0]  CH_NONE   = 5'd31;
  localparam logic [CNT_W-1:0] AVG_RESET = 8'd16;
  localparam logic [CNT_W-1:0] AVG_MIN   = 8'd1;

  // Item function codes.
  localparam logic [1:0] FN_SAMPLE = 2'd0;
  localparam logic [1:0] FN_START  = 2'd1;
  localparam logic [1:0] FN_READ   = 2'd2;

  // Register indexes.
  localparam logic [1:0] CFG_MASK = 2'd0;
  localparam logic [1:0] CFG_AVG  = 2'd1;
  localparam logic [1:0] CFG_FREE = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } scan_stat_t;

endpackage

`default_nettype wire

// ----- rtl/adc_sas_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module adc_sas_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [adc_sas_pkg::ACC_W-1:0] dividend,
  input  logic [adc_sas_pkg::CNT_W-1:0] divisor,
  output adc_sas_pkg::div_stat_t        stat,
  output logic [adc_sas_pkg::ACC_W-1:0] quotient
);
  import adc_sas_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(ACC_W - 1);

  logic [ACC_W-1:0]     dvd;
  logic [CNT_W-1:0]     dsr;
  logic [CNT_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] step;
  logic                 busy;
  logic                 done;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 qbit;

  // One restoring step per cycle: shift in the next dividend bit, try the subtract.
  assign trial = {rem, dvd[ACC_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign qbit  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      step     <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[ACC_W-2:0], 1'b0};
      rem      <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quotient <= {quotient[ACC_W-2:0], qbit};
      step     <= step + 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ----- rtl/adc_sas_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module adc_sas_scan #(
  parameter int CHANNELS = adc_sas_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [adc_sas_pkg::CH_W-1:0]     cur,
  input  logic [adc_sas_pkg::CH_SLOTS-1:0] live,
  output adc_sas_pkg::scan_stat_t          stat,
  output logic [adc_sas_pkg::CH_W-1:0]     chan
);
  import adc_sas_pkg::*;

  logic [CH_W-1:0] cand;
  logic            busy;
  logic            done;
  logic            found;

  // Next candidate after c, wrapping at the channel count.
  function automatic logic [CH_W-1:0] step_ch(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] n;
    n = c + 1'b1;
    if ({1'b0, n} >= (CH_W + 1)'(CHANNELS)) begin
      n = '0;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        found <= 1'b0;
        if (live == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && live[cand]) begin
        busy  <= 1'b0;
        done  <= 1'b1;
        found <= 1'b1;
      end
    end
  end

  // One candidate channel is tested per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      cand <= step_ch(cur);
    end else if (busy && !live[cand]) begin
      cand <= step_ch(cand);
    end
  end

  assign chan       = cand;
  assign stat.busy  = busy;
  assign stat.done  = done;
  assign stat.found = found;

endmodule

`default_nettype wire

// ----- rtl/adc_sas_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module adc_sas_store #(
  parameter int CHANNELS = adc_sas_pkg::CHANNELS_DEF,
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [adc_sas_pkg::RES_W-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [adc_sas_pkg::RES_W-1:0] rdata
);
  import adc_sas_pkg::*;

  logic [RES_W-1:0]    mem [CHANNELS];
  logic [CHANNELS-1:0] valid;
  logic [RES_W-1:0]    mem_q;
  logic                valid_q;

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      mem_q   <= mem[raddr];
      valid_q <= valid[raddr];
    end
  end

  assign rdata = valid_q ? mem_q : '0;

endmodule

`default_nettype wire

// ----- rtl/adc_scan_average_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                   Words carried
// item      item_valid / item_stall     func, sample, read_channel
// result    result_valid / result_stall start_conversion, convert_channel,
//                                       average_stored, read_value
// config    cfg_write                   cfg_index, cfg_data
//
// One item is worked at a time and gives exactly one result word. A sample that does not
// close an average and an unused code go straight to S_OUT, a read by way of S_READ.
// A start searches in S_SCAN, one channel a cycle, and finds none if none is enabled.
// A closing sample waits in S_DIV for 20 divider steps, then searches too in free-run.
// Reset is synchronous and needs no clearing pass: the result store has a valid bit per
// entry. A stalled result is held while the next item is accepted and worked.

`include "adc_scan_average_sequencer_defines.svh"

module adc_scan_average_sequencer #(
  parameter int CHANNELS    = adc_sas_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = adc_sas_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [adc_sas_pkg::CFG_W-1:0]  cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [1:0]                     func,
  input  logic [adc_sas_pkg::SMP_W-1:0]  sample,
  input  logic [adc_sas_pkg::CH_W-1:0]   read_channel,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           start_conversion,
  output logic [adc_sas_pkg::CH_W-1:0]   convert_channel,
  output logic                           average_stored,
  output logic [adc_sas_pkg::RES_W-1:0]  read_value
);
  import adc_sas_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_SLOTS-1:0] CH_MASK = CH_SLOTS'((64'd1 << CHANNELS) - 64'd1);
  localparam logic [SMP_W-1:0]    SMP_MASK = SMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [ACC_W-1:0]    SAT_MAX = ACC_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Configuration registers.
  logic [MASK_W-1:0] enabled_mask;
  logic [CNT_W-1:0]  average_count;
  logic              free_run;

  // Scan and averaging state.
  logic [2:0]        state;
  logic [CH_W-1:0]   cur_channel;
  logic [ACC_W-1:0]  accumulator;
  logic [CNT_W-1:0]  sample_count;
  logic              rd_in_range;

  // Result word under construction.
  logic              res_start;
  logic [CH_W-1:0]   res_chan;
  logic              res_stored;
  logic [RES_W-1:0]  res_rval;

  logic              accept;
  logic              out_free;
  logic [SMP_W-1:0]  smp_eff;
  logic [ACC_W-1:0]  acc_sum;
  logic [CNT_W-1:0]  cnt_sum;
  logic              complete;
  logic              cur_in_range;
  logic [CH_SLOTS-1:0] live;
  logic [ACC_W-1:0]  avg_sat;

  div_stat_t         div_stat;
  logic              div_start;
  logic [ACC_W-1:0]  quotient;

  scan_stat_t        scan_stat;
  logic              scan_start;
  logic [CH_W-1:0]   scan_chan;

  logic              st_we;
  logic              st_re;
  logic [RES_W-1:0]  st_rdata;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  assign smp_eff      = sample & SMP_MASK;
  assign acc_sum      = accumulator + {{CNT_W{1'b0}}, smp_eff};
  assign cnt_sum      = sample_count + 1'b1;
  assign complete     = (cnt_sum >= average_count);
  assign cur_in_range = ({1'b0, cur_channel} < (CH_W + 1)'(CHANNELS));
  assign live         = {{(CH_SLOTS - MASK_W){1'b0}}, enabled_mask} & CH_MASK;
  assign avg_sat      = (quotient > SAT_MAX) ? SAT_MAX : quotient;

  assign div_start  = accept && (func == FN_SAMPLE) && complete;
  assign scan_start = (accept && (func == FN_START)) ||
                      ((state == S_DIV) && div_stat.done && cur_in_range && free_run);
  assign st_we      = (state == S_DIV) && div_stat.done && cur_in_range;
  assign st_re      = accept && (func == FN_READ);

  adc_sas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_sum),
    .divisor  (average_count),
    .stat     (div_stat),
    .quotient (quotient)
  );

  adc_sas_scan #(
    .CHANNELS (CHANNELS)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .cur   (cur_channel),
    .live  (live),
    .stat  (scan_stat),
    .chan  (scan_chan)
  );

  adc_sas_store #(
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (st_we),
    .waddr (cur_channel[AW-1:0]),
    .wdata (avg_sat[RES_W-1:0]),
    .re    (st_re),
    .raddr (read_channel[AW-1:0]),
    .rdata (st_rdata)
  );

  // Configuration writes; an average count of zero is taken as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_mask  <= '0;
      average_count <= AVG_RESET;
      free_run      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MASK: enabled_mask <= cfg_data[MASK_W-1:0];
        CFG_AVG:  average_count <= (cfg_data[CNT_W-1:0] == '0) ? AVG_MIN
                                                               : cfg_data[CNT_W-1:0];
        CFG_FREE: free_run <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  // Sequencer. The store is written only in S_DIV and read only on an accepted read word,
  // so its accesses never overlap and need no forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur_channel  <= CH_NONE;
      accumulator  <= '0;
      sample_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_start  <= 1'b0;
            res_chan   <= '0;
            res_stored <= 1'b0;
            res_rval   <= '0;
            unique case (func)
              FN_SAMPLE: begin
                if (complete) begin
                  accumulator  <= '0;
                  sample_count <= '0;
                  state        <= S_DIV;
                end else begin
                  accumulator  <= acc_sum;
                  sample_count <= cnt_sum;
                  res_start    <= cur_in_range;
                  res_chan     <= cur_in_range ? cur_channel : '0;
                  state        <= S_OUT;
                end
              end
              FN_START: state <= S_SCAN;
              FN_READ: begin
                rd_in_range <= ({1'b0, read_channel} < (CH_W + 1)'(CHANNELS));
                state       <= S_READ;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            res_stored <= cur_in_range;
            state      <= (cur_in_range && free_run) ? S_SCAN : S_OUT;
          end
        end
        S_SCAN: begin
          if (scan_stat.done) begin
            if (scan_stat.found) begin
              cur_channel <= scan_chan;
              res_start   <= 1'b1;
              res_chan    <= scan_chan;
            end
            state <= S_OUT;
          end
        end
        S_READ: begin
          res_rval <= rd_in_range ? st_rdata : '0;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: holds a stalled result word while the next item is worked.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      start_conversion <= res_start;
      convert_channel  <= res_chan;
      average_stored   <= res_stored;
      read_value       <= res_rval;
    end
  end

  `ASAS_ASSERT_NOW(a_idle_units_quiet, state == S_IDLE, !div_stat.busy && !scan_stat.busy,
                   "divider or channel search busy while idle")
  `ASAS_ASSERT_NOW(a_chan_in_range, result_valid && start_conversion,
                   {1'b0, convert_channel} < (CH_W + 1)'(CHANNELS),
                   "conversion requested on a channel out of range")
  `ASAS_ASSERT_NOW(a_restart_needs_free_run, result_valid && average_stored && start_conversion,
                   free_run, "next channel started without free-run")
  `ASAS_ASSERT_NEXT(a_read_goes_to_store, accept && func == FN_READ, state == S_READ,
                    "read word did not wait for the store")

endmodule

`default_nettype wire
